// ===== design/dbeg_pkg.sv =====
// ----------------------------------------------------------------------------
// dbeg_pkg
// Shared types, register map and constants of the beep envelope generator.
// ----------------------------------------------------------------------------
package dbeg_pkg;

    // register map of the configuration port
    typedef enum logic [2:0] {
        CFG_PHASE_STEP   = 3'd0,
        CFG_ATTACK_STEP  = 3'd1,
        CFG_DECAY_STEP   = 3'd2,
        CFG_ATTACK_TICKS = 3'd3,
        CFG_DECAY_TICKS  = 3'd4,
        CFG_BEEP_TICKS   = 3'd5,
        CFG_GAP_TICKS    = 3'd6
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [31:0] RST_PHASE_STEP   = 32'd34359738;
    localparam logic [15:0] RST_ATTACK_STEP  = 16'd131;
    localparam logic [15:0] RST_DECAY_STEP   = 16'd131;
    localparam logic [15:0] RST_ATTACK_TICKS = 16'd250;
    localparam logic [15:0] RST_DECAY_TICKS  = 16'd250;
    localparam logic [15:0] RST_BEEP_TICKS   = 16'd10500;
    localparam logic [15:0] RST_GAP_TICKS    = 16'd50000;

    // dac command framing
    localparam logic [15:0] DAC_CFG_BITS = 16'b1011000000000000;
    localparam logic [15:0] DAC_OFFSET   = 16'd2048;

    // sine table scaling: 2047 * 32768, angle spans 6.283 rad
    localparam real ROM_SCALE  = 67076096.0;
    localparam real ROM_SPAN   = 6.283;
    localparam int  ROM_W      = 28;
    localparam int  PROD_SHIFT = 30;

    // configuration register set
    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] attack_step;
        logic [15:0] decay_step;
        logic [15:0] attack_ticks;
        logic [15:0] decay_ticks;
        logic [15:0] beep_ticks;
        logic [15:0] gap_ticks;
    } t_cfg;

    // one sounding tick handed from the envelope to the sample pipe
    typedef struct packed {
        logic        emit;
        logic [31:0] phase;
        logic [31:0] amp;
    } t_voice;

    // one sine table entry, evaluated at elaboration only
    function automatic logic signed [ROM_W-1:0] sine_entry(int i, real step);
        real ang;
        real v;
        ang = real'(i) * step;
        v   = ROM_SCALE * $sin(ang);
        return ROM_W'($rtoi(v));
    endfunction

endpackage

// ===== design/dbeg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// dbeg_sine_rom
// Constant sine table with a registered read port.
// ----------------------------------------------------------------------------
module dbeg_sine_rom #(
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [$clog2(DEPTH)-1:0]          i_addr,
    output logic signed [dbeg_pkg::ROM_W-1:0] o_data
);

    localparam int  AW       = $clog2(DEPTH);
    localparam real ANG_STEP = dbeg_pkg::ROM_SPAN / DEPTH;

    typedef logic signed [dbeg_pkg::ROM_W-1:0] t_rom_table [DEPTH];

    function automatic t_rom_table build_table();
        t_rom_table t;
        for (int i = 0; i < DEPTH; i++) begin
            t[i] = dbeg_pkg::sine_entry(i, ANG_STEP);
        end
        return t;
    endfunction

    localparam t_rom_table ROM_TABLE = build_table();

    logic signed [dbeg_pkg::ROM_W-1:0] r_data;

    // registered read, held while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= ROM_TABLE[i_addr[AW-1:0]];
        end
    end

    assign o_data = r_data;

endmodule

// ===== design/dbeg_envelope.sv =====
// ----------------------------------------------------------------------------
// dbeg_envelope
// Beep/gap sequencer: phase accumulator, amplitude ramp and tick counter.
// ----------------------------------------------------------------------------
module dbeg_envelope (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_tick,
    input  dbeg_pkg::t_cfg   i_cfg,
    output dbeg_pkg::t_voice o_voice
);

    logic [31:0] r_phase_acc, n_phase_acc;
    logic [31:0] r_amp, n_amp;
    logic [15:0] r_tick_count, n_tick_count;
    logic        r_silent, n_silent;
    logic [15:0] w_count_inc;
    logic [16:0] w_decay_edge;
    logic        w_step;

    assign w_step       = i_accept && i_tick;
    assign w_count_inc  = r_tick_count + 16'd1;
    assign w_decay_edge = {1'b0, r_tick_count} + {1'b0, i_cfg.decay_ticks};

    // next state of the burst sequencer
    always_comb begin
        n_phase_acc  = r_phase_acc;
        n_amp        = r_amp;
        n_tick_count = r_tick_count;
        n_silent     = r_silent;
        if (w_step) begin
            n_tick_count = w_count_inc;
            if (!r_silent) begin
                n_phase_acc = r_phase_acc + i_cfg.phase_step;
                // attack ramp first, then the decay window at the end
                if (r_tick_count < i_cfg.attack_ticks) begin
                    n_amp = r_amp + {16'd0, i_cfg.attack_step};
                end else if (w_decay_edge > {1'b0, i_cfg.beep_ticks}) begin
                    n_amp = r_amp - {16'd0, i_cfg.decay_step};
                end
                if (w_count_inc == i_cfg.beep_ticks) begin
                    n_silent     = 1'b1;
                    n_tick_count = '0;
                end
            end else if (w_count_inc == i_cfg.gap_ticks) begin
                n_amp        = '0;
                n_silent     = 1'b0;
                n_tick_count = '0;
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_amp        <= '0;
            r_tick_count <= '0;
            r_silent     <= 1'b0;
        end else begin
            r_phase_acc  <= n_phase_acc;
            r_amp        <= n_amp;
            r_tick_count <= n_tick_count;
            r_silent     <= n_silent;
        end
    end

    // the sample uses the advanced phase and the amplitude before the ramp step
    assign o_voice.emit  = w_step && !r_silent;
    assign o_voice.phase = n_phase_acc;
    assign o_voice.amp   = r_amp;

    // a beep ends only on a sounding tick
    a_beep_end_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_silent) |-> $past(w_step && !r_silent))
        else $error("gap phase entered without a sounding tick");

    // each phase change restarts the counter
    a_count_restart: assert property (@(posedge i_clk)
        (r_silent != $past(r_silent)) |-> (r_tick_count == 16'd0))
        else $error("tick counter not cleared on phase change");

    // every beep starts from silence
    a_beep_starts_silent: assert property (@(posedge i_clk)
        $fell(r_silent) |-> (r_amp == 32'd0))
        else $error("amplitude not cleared at beep start");

endmodule

// ===== design/dbeg_sample_pipe.sv =====
// ----------------------------------------------------------------------------
// dbeg_sample_pipe
// Stalling sample pipeline: table index, sine lookup, scaling, dac framing.
// ----------------------------------------------------------------------------
module dbeg_sample_pipe #(
    parameter int SINE_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dbeg_pkg::t_voice i_voice,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [15:0]      o_dac_word
);

    localparam int AW = $clog2(SINE_ENTRIES);
    localparam int SW = 32 + AW;
    localparam int PW = 32 + dbeg_pkg::ROM_W;

    logic                              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic                              r_out_valid;
    logic [31:0]                       r_s1_phase;
    logic [31:0]                       r_s1_amp, r_s2_amp, r_s3_amp;
    logic [AW-1:0]                     r_s2_idx;
    logic [15:0]                       r_s4_sample;
    logic [15:0]                       r_dac_word;
    logic                              w_take1, w_take2, w_take3, w_take4, w_move_out;
    logic [SW-1:0]                     w_scaled;
    logic signed [dbeg_pkg::ROM_W-1:0] w_rom_data;
    logic signed [PW-1:0]              w_prod;

    // a stage loads when it is empty or its contents move on
    assign w_move_out = !r_out_valid || !i_stall;
    assign w_take4    = !r_s4_valid || w_move_out;
    assign w_take3    = !r_s3_valid || w_take4;
    assign w_take2    = !r_s2_valid || w_take3;
    assign w_take1    = !r_s1_valid || w_take2;

    // phase to table index
    assign w_scaled = SW'(r_s1_phase) * SW'(SINE_ENTRIES);

    // amplitude times sine
    assign w_prod = $signed(r_s3_amp) * w_rom_data;

    dbeg_sine_rom #(
        .DEPTH (SINE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_take3),
        .i_addr (r_s2_idx),
        .o_data (w_rom_data)
    );

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take1)    r_s1_valid  <= i_voice.emit;
            if (w_take2)    r_s2_valid  <= r_s1_valid;
            if (w_take3)    r_s3_valid  <= r_s2_valid;
            if (w_take4)    r_s4_valid  <= r_s3_valid;
            if (w_move_out) r_out_valid <= r_s4_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_take1) begin
            r_s1_phase <= i_voice.phase;
            r_s1_amp   <= i_voice.amp;
        end
        if (w_take2) begin
            r_s2_idx <= w_scaled[32 +: AW];
            r_s2_amp <= r_s1_amp;
        end
        if (w_take3) begin
            r_s3_amp <= r_s2_amp;
        end
        if (w_take4) begin
            r_s4_sample <= w_prod[dbeg_pkg::PROD_SHIFT +: 16];
        end
        if (w_move_out) begin
            r_dac_word <= dbeg_pkg::DAC_CFG_BITS | (r_s4_sample + dbeg_pkg::DAC_OFFSET);
        end
    end

    assign o_ready    = w_take1;
    assign o_valid    = r_out_valid;
    assign o_dac_word = r_dac_word;

    // a held result keeps a full stage four from moving on
    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> (!w_take4 || !r_s4_valid))
        else $error("stage four would overwrite a held result");

    // a stalled dac beat stays valid and unchanged
    a_stalled_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_dac_word)))
        else $error("stalled dac word changed");

    // the dac framing bits are always present
    a_frame_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_dac_word[15] && r_dac_word[13] && r_dac_word[12]))
        else $error("dac command bits missing");

endmodule

// ===== design/dds_beep_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// dds_beep_envelope_generator
// Tone burst generator: sine dds with a linear attack/decay envelope.
// ----------------------------------------------------------------------------
// Usage:
//   tick channel (i_tick_valid, o_tick_stall, i_tick): one beat per sample
//   period. A beat with i_tick low changes nothing. In the beep phase every
//   tick beat yields one dac word; in the gap phase tick beats only count.
//   dac channel (o_dac_word_valid, i_dac_word_stall, o_dac_word): one beat
//   per sounding tick, in tick order.
//   config channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data):
//   always ready; 16-bit registers take the low data bits, unknown indexes
//   are dropped. Write only while no sounding tick is in flight.
// Timing:
//   one tick beat per cycle while o_tick_stall is low; each dac word passes the
//   input, index, table read, multiply and framing registers in that order.
// Reset (synchronous, active low): registers return to their defaults,
//   phase, amplitude and counter clear, the block starts in the beep phase.
// Stall: a stalled dac word holds; the pipe keeps taking ticks until all
//   five stage registers are full, then o_tick_stall rises.
// ----------------------------------------------------------------------------
module dds_beep_envelope_generator #(
    parameter int SINE_ENTRIES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick channel
    input  logic                            i_tick_valid,
    output logic                            o_tick_stall,
    input  logic                            i_tick,
    // dac word channel
    output logic                            o_dac_word_valid,
    input  logic                            i_dac_word_stall,
    output logic [15:0]                     o_dac_word,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dbeg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbeg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dbeg_pkg::t_cfg   r_cfg;
    dbeg_pkg::t_voice w_voice;
    logic             w_pipe_ready;
    logic             w_accept;

    assign o_cfg_ready  = 1'b1;
    assign o_tick_stall = !w_pipe_ready;
    assign w_accept     = i_tick_valid && w_pipe_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= dbeg_pkg::RST_PHASE_STEP;
            r_cfg.attack_step  <= dbeg_pkg::RST_ATTACK_STEP;
            r_cfg.decay_step   <= dbeg_pkg::RST_DECAY_STEP;
            r_cfg.attack_ticks <= dbeg_pkg::RST_ATTACK_TICKS;
            r_cfg.decay_ticks  <= dbeg_pkg::RST_DECAY_TICKS;
            r_cfg.beep_ticks   <= dbeg_pkg::RST_BEEP_TICKS;
            r_cfg.gap_ticks    <= dbeg_pkg::RST_GAP_TICKS;
        end else if (i_cfg_valid) begin
            unique case (dbeg_pkg::t_cfg_reg'(i_cfg_index))
                dbeg_pkg::CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_data;
                dbeg_pkg::CFG_ATTACK_STEP:  r_cfg.attack_step  <= i_cfg_data[15:0];
                dbeg_pkg::CFG_DECAY_STEP:   r_cfg.decay_step   <= i_cfg_data[15:0];
                dbeg_pkg::CFG_ATTACK_TICKS: r_cfg.attack_ticks <= i_cfg_data[15:0];
                dbeg_pkg::CFG_DECAY_TICKS:  r_cfg.decay_ticks  <= i_cfg_data[15:0];
                dbeg_pkg::CFG_BEEP_TICKS:   r_cfg.beep_ticks   <= i_cfg_data[15:0];
                dbeg_pkg::CFG_GAP_TICKS:    r_cfg.gap_ticks    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dbeg_envelope u_envelope (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_tick   (i_tick),
        .i_cfg    (r_cfg),
        .o_voice  (w_voice)
    );

    dbeg_sample_pipe #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_voice    (w_voice),
        .o_ready    (w_pipe_ready),
        .o_valid    (o_dac_word_valid),
        .i_stall    (i_dac_word_stall),
        .o_dac_word (o_dac_word)
    );

endmodule

// ===== tb/dbeg_tone_checker.sv =====
// ----------------------------------------------------------------------------
// dbeg_tone_checker
// Watches the tick, dac word and config channels of the beep envelope
// generator, predicts every dac word from its own copy of the phase, envelope
// and burst state, and compares each dac beat against the oldest prediction.
// ----------------------------------------------------------------------------
module dbeg_tone_checker
    import dbeg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_stall,
    input  logic                  i_tick,
    input  logic                  i_dac_word_valid,
    input  logic                  i_dac_word_stall,
    input  logic [15:0]           i_dac_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_words_due,
    output int                    o_fail_count,
    output logic                  o_gap_phase,
    output logic [15:0]           o_tick_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_SIZE = 256;
    localparam int          MAX_SHOWN  = 10;
    // angles in q61: pi, pi/2 and the 6.283 rad span of the table
    localparam logic [63:0] Q61_PI      = 64'h6487ED5110B4611A;
    localparam logic [63:0] Q61_HALF_PI = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q61_SPAN    = 64'd14487611626889639100;
    localparam logic [63:0] SINE_GAIN   = 64'd67076096;

    logic signed [31:0] sine_tab [TABLE_SIZE];

    // mirrored registers and burst state
    t_cfg        cfg;
    logic [31:0] ph_acc;
    logic [31:0] env_amp;
    logic [15:0] tick_cnt;
    logic        silent;

    logic [15:0] due_words [$];
    int          fails;

    assign o_words_due  = due_words.size();
    assign o_fail_count = fails;
    assign o_gap_phase  = silent;
    assign o_tick_count = tick_cnt;

    // q61 product, truncated
    function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // taylor series sine on [0, pi/2], q61 in and out
    function automatic logic [63:0] q61_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        x2   = q61_mul(x, x);
        term = x;
        acc  = x;
        for (k = 1; k <= 13; k++) begin
            term = q61_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // sine table, folded into the first quadrant
    initial begin : fill_sine_tab
        logic [63:0] step_q;
        logic [63:0] step_r;
        logic [63:0] ang;
        logic [63:0] mag;
        logic        neg;
        step_q = Q61_SPAN / TABLE_SIZE;
        step_r = Q61_SPAN % TABLE_SIZE;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            ang = step_q * 64'(i) + (step_r * 64'(i)) / TABLE_SIZE;
            neg = 1'b0;
            if (ang >= Q61_PI) begin
                ang = ang - Q61_PI;
                neg = 1'b1;
            end
            if (ang > Q61_HALF_PI)
                ang = Q61_PI - ang;
            mag = q61_mul(q61_sin(ang), SINE_GAIN);
            sine_tab[i] = neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
        end
    end

    // one accepted tick of level one: advance the burst, maybe yield a word
    task automatic advance_burst(output bit emits, output logic [15:0] word);
        int                 slot;
        logic signed [63:0] prod;
        logic [15:0]        level;
        emits = 1'b0;
        word  = '0;
        if (!silent) begin
            ph_acc = ph_acc + cfg.phase_step;
            slot   = int'(({32'd0, ph_acc} * TABLE_SIZE) >> 32);
            prod   = $signed(env_amp) * sine_tab[slot];
            level  = prod[45:30] + DAC_OFFSET;
            word   = DAC_CFG_BITS | level;
            emits  = 1'b1;
            // linear envelope: attack window first, then decay window at the end
            if (tick_cnt < cfg.attack_ticks)
                env_amp = env_amp + 32'(cfg.attack_step);
            else if (17'(tick_cnt) + 17'(cfg.decay_ticks) > 17'(cfg.beep_ticks))
                env_amp = env_amp - 32'(cfg.decay_step);
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt == cfg.beep_ticks) begin
                silent   = 1'b1;
                tick_cnt = '0;
            end
        end else begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt == cfg.gap_ticks) begin
                env_amp  = '0;
                silent   = 1'b0;
                tick_cnt = '0;
            end
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin : watch
        logic [15:0] want;
        bit          emits;
        if (!i_rst_n) begin
            cfg.phase_step   = RST_PHASE_STEP;
            cfg.attack_step  = RST_ATTACK_STEP;
            cfg.decay_step   = RST_DECAY_STEP;
            cfg.attack_ticks = RST_ATTACK_TICKS;
            cfg.decay_ticks  = RST_DECAY_TICKS;
            cfg.beep_ticks   = RST_BEEP_TICKS;
            cfg.gap_ticks    = RST_GAP_TICKS;
            ph_acc   = '0;
            env_amp  = '0;
            tick_cnt = '0;
            silent   = 1'b0;
            due_words.delete();
        end else begin
            // config beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_PHASE_STEP:   cfg.phase_step   = i_cfg_data;
                    CFG_ATTACK_STEP:  cfg.attack_step  = i_cfg_data[15:0];
                    CFG_DECAY_STEP:   cfg.decay_step   = i_cfg_data[15:0];
                    CFG_ATTACK_TICKS: cfg.attack_ticks = i_cfg_data[15:0];
                    CFG_DECAY_TICKS:  cfg.decay_ticks  = i_cfg_data[15:0];
                    CFG_BEEP_TICKS:   cfg.beep_ticks   = i_cfg_data[15:0];
                    CFG_GAP_TICKS:    cfg.gap_ticks    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // dac beat against the oldest prediction
            if (i_dac_word_valid && !i_dac_word_stall) begin
                if (due_words.size() == 0) begin
                    if (fails < MAX_SHOWN)
                        $display("%0t: dac word %h with none expected", $realtime, i_dac_word);
                    fails++;
                end else begin
                    want = due_words.pop_front();
                    if (i_dac_word !== want) begin
                        if (fails < MAX_SHOWN)
                            $display("%0t: dac word expected %h got %h",
                                     $realtime, want, i_dac_word);
                        fails++;
                    end
                end
            end
            // tick beat, a low tick changes nothing
            if (i_tick_valid && !i_tick_stall && i_tick) begin
                advance_burst(emits, want);
                if (emits)
                    due_words.push_back(want);
            end
        end
    end

endmodule

// ===== tb/tb_dds_beep_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// tb_dds_beep_envelope_generator
// Drives tick beats and register writes into the beep envelope generator with
// random tick idling and random dac stalls; a separate checker predicts and
// compares every dac word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_dds_beep_envelope_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import dbeg_pkg::*;

    localparam int                   CYCLE_LIMIT  = 3_000_000;
    localparam int                   DRAIN_CYCLES = 16;
    localparam int                   RANDOM_TICKS = 800;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  tick_valid = 1'b0;
    logic                  tick_stall;
    logic                  tick       = 1'b0;
    logic                  dac_valid;
    logic                  dac_stall  = 1'b0;
    logic [15:0]           dac_word;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int                    words_due;
    int                    fail_count;
    logic                  gap_phase;
    logic [15:0]           tick_count;
    bit                    quiet      = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dds_beep_envelope_generator DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_tick_valid     (tick_valid),
        .o_tick_stall     (tick_stall),
        .i_tick           (tick),
        .o_dac_word_valid (dac_valid),
        .i_dac_word_stall (dac_stall),
        .o_dac_word       (dac_word),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    dbeg_tone_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_tick_valid     (tick_valid),
        .i_tick_stall     (tick_stall),
        .i_tick           (tick),
        .i_dac_word_valid (dac_valid),
        .i_dac_word_stall (dac_stall),
        .i_dac_word       (dac_word),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_words_due      (words_due),
        .o_fail_count     (fail_count),
        .o_gap_phase      (gap_phase),
        .o_tick_count     (tick_count)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // q15 envelope step with its extremes
    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'd32768;
        return 32'($urandom_range(0, 32768));
    endfunction

    // tick count, mostly short, sometimes zero or full scale
    function automatic logic [15:0] pick_count(input int typ_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'hFFFF;
        if (r < 12)
            return 16'd0;
        return 16'($urandom_range(0, typ_hi));
    endfunction

    // one tick beat after a random idle stretch
    task automatic push_tick(input bit level);
        int gap;
        gap = quiet ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge clk);
            tick_valid <= 1'b0;
        end
        @(negedge clk);
        tick_valid <= 1'b1;
        tick       <= level;
        do @(posedge clk); while (tick_stall);
    endtask

    // one register write; 16-bit registers get junk in the upper data bits
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        logic [31:0] value;
        value = data;
        if (idx != CFG_PHASE_STEP)
            value[31:16] = 16'($urandom());
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold off ticks until every dac word is out and the pipe has drained
    task automatic settle();
        @(negedge clk);
        tick_valid <= 1'b0;
        wait (words_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // dac side stall pattern
    initial begin : dac_sink
        int run;
        bit hold;
        run  = 0;
        hold = 1'b0;
        forever begin
            @(negedge clk);
            if (quiet) begin
                run = 0;
                dac_stall <= 1'b0;
            end else begin
                if (run == 0) begin
                    hold = ($urandom_range(0, 2) == 0);
                    run  = hold ? 1 + pick_gap() : $urandom_range(1, 6);
                end
                run--;
                dac_stall <= hold;
            end
        end
    end

    // run limit
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("dds_beep_envelope_generator verification failed");
        $finish;
    end

    initial begin : stimulus
        int          sent;
        int          n;
        logic [15:0] len;
        sent = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults, one low tick in between
        repeat (4) push_tick(1'b1);
        push_tick(1'b0);
        repeat (2) push_tick(1'b1);

        // full-scale steps, short attack/hold/decay, short gap, next burst
        settle();
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_ATTACK_STEP, 32'd32768);
        write_reg(CFG_DECAY_STEP, 32'd32768);
        write_reg(CFG_ATTACK_TICKS, 32'(tick_count + 16'd3));
        write_reg(CFG_DECAY_TICKS, 32'd2);
        write_reg(CFG_BEEP_TICKS, 32'(tick_count + 16'd6));
        write_reg(CFG_GAP_TICKS, 32'd2);
        repeat (12) push_tick(1'b1);

        // frozen phase, decay window longer than the beep, amplitude wraps below zero
        settle();
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_ATTACK_STEP, 32'd0);
        write_reg(CFG_ATTACK_TICKS, 32'd0);
        write_reg(CFG_DECAY_TICKS, 32'hFFFF);
        write_reg(CFG_BEEP_TICKS, 32'((gap_phase ? 16'd0 : tick_count) + 16'd5));
        write_reg(CFG_GAP_TICKS, 32'd1);
        write_reg(CFG_NO_REG, $urandom());
        repeat (7) push_tick(1'b1);

        // random bursts, each under a fresh register setting
        while (sent < RANDOM_TICKS) begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) begin
                n = $urandom_range(0, 9);
                write_reg(CFG_PHASE_STEP,
                          n == 0 ? 32'd0 : n == 1 ? 32'hFFFF_FFFF : 32'($urandom()));
            end
            if ($urandom_range(0, 1))
                write_reg(CFG_ATTACK_STEP, pick_step());
            if ($urandom_range(0, 1))
                write_reg(CFG_DECAY_STEP, pick_step());
            if ($urandom_range(0, 1))
                write_reg(CFG_ATTACK_TICKS, 32'(pick_count(24)));
            if ($urandom_range(0, 1))
                write_reg(CFG_DECAY_TICKS, 32'(pick_count(24)));
            // lengths stay ahead of the running count so a phase cannot wrap
            if ($urandom_range(0, 1)) begin
                len = pick_count(24);
                if (len == 0 || (!gap_phase && len <= tick_count))
                    len = (gap_phase ? 16'd0 : tick_count) + 16'($urandom_range(1, 12));
                write_reg(CFG_BEEP_TICKS, 32'(len));
            end
            if ($urandom_range(0, 1)) begin
                len = pick_count(12);
                if (len == 0 || (gap_phase && len <= tick_count))
                    len = (gap_phase ? tick_count : 16'd0) + 16'($urandom_range(1, 8));
                write_reg(CFG_GAP_TICKS, 32'(len));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_NO_REG, $urandom());

            n = $urandom_range(10, 60);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) begin
                    push_tick(1'b0);
                end else begin
                    push_tick(1'b1);
                    sent++;
                end
            end
        end

        // drain and verdict
        @(negedge clk);
        tick_valid <= 1'b0;
        wait (words_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("dds_beep_envelope_generator verification clean");
        else
            $display("dds_beep_envelope_generator verification failed");
        $finish;
    end

endmodule
